// ===== rtl/assert_macros.svh =====
// Assertion macros for the bin mask unit.
// Needs clk_i and rst_ni in the scope of the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen.
`define ASSERT_NEVER(lbl, cond, msg) \
  `ASSERT_CLK(lbl, !(cond), msg)

`endif

// ===== rtl/pcbm_pkg.sv =====
// Shared widths, register indexes, sequencer states and the arctangent table
// for the phase coherence bin mask unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcbm_pkg;

  localparam int unsigned MaxMics     = 8;
  localparam int unsigned SampleWidth = 24;
  localparam int unsigned AngleWidth  = 16;
  localparam int unsigned MicIdxW     = 3;
  localparam int unsigned CountW      = 4;
  localparam int unsigned MagSumW     = 27;
  localparam int unsigned PhSumW      = 20;
  localparam int unsigned ProdW       = 48;
  localparam int unsigned CordicW     = 43;
  localparam int unsigned CfgAddrW    = 3;
  localparam int unsigned CfgDataW    = 23;

  typedef enum logic [CfgAddrW-1:0] {
    REG_MIC_COUNT   = 3'd0,
    REG_WINDOW_LOG2 = 3'd1,
    REG_MAG_THRESH  = 3'd2,
    REG_ATTEN_GAIN  = 3'd3,
    REG_PH_THRESH   = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQ_RE,
    ST_SQ_IM,
    ST_ROOT_LD,
    ST_ROOT_VEC,
    ST_FIX,
    ST_PAIR,
    ST_MEAN_DIV,
    ST_DECIDE,
    ST_GAIN,
    ST_SELECT,
    ST_SCL_MUL,
    ST_SCL_DIV,
    ST_SCL_FIX,
    ST_OUT
  } pcbm_state_e;

  // atan(2^-i), 2^32 per turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/phase_coherence_bin_mask_unit.sv =====
// Phase coherence bin mask: top level, one sequencer around a shared multiplier,
// square root / CORDIC step and restoring divider. Uses pcbm_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

// channel  | direction | handshake                | payload
// in       | sink      | in_valid_i / in_stall_o  | bin_re, bin_im, steer_phase, dc_bin
// out      | source    | out_valid_o / out_stall_i| enhanced_re/im, interference_re/im
// cfg      | sink      | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
//
// A mic beat stalls the input for 2 squarings, a 32-step CORDIC beside the 24-step
// root and i compares (i = its place in the bin). The last mic of a bin adds a 48-step
// mean division and, unless the bin is DC, a second root and up to two more such divisions.
// Reset sets configuration to defaults, clears count, sums, reference; no clearing pass.
// A finished bin waits in the output register; a stalled output holds only the next bin.

module phase_coherence_bin_mask_unit
  import pcbm_pkg::*;
(
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [CfgAddrW-1:0]          cfg_addr_i,
  input  wire logic [CfgDataW-1:0]          cfg_wdata_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [SampleWidth-1:0] bin_re_i,
  input  wire logic signed [SampleWidth-1:0] bin_im_i,
  input  wire logic signed [AngleWidth-1:0]  steer_phase_i,
  input  wire logic                         dc_bin_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed [SampleWidth-1:0]     enhanced_re_o,
  output logic signed [SampleWidth-1:0]     enhanced_im_o,
  output logic signed [SampleWidth-1:0]     interference_re_o,
  output logic signed [SampleWidth-1:0]     interference_im_o
);

  localparam logic [SampleWidth-1:0] SatHi = {1'b0, {(SampleWidth-1){1'b1}}};
  localparam logic [SampleWidth-1:0] SatLo = {1'b1, {(SampleWidth-1){1'b0}}};
  localparam logic [AngleWidth-1:0]  Half  = {1'b1, {(AngleWidth-1){1'b0}}};
  localparam logic [PhSumW-1:0]      PhSumMax = PhSumW'(28 * 32768);

  pcbm_state_e state_q, state_d;

  // configuration
  logic [3:0]  mic_count_q, window_log2_q;
  logic [22:0] mag_thresh_q;
  logic [15:0] atten_gain_q;
  logic [14:0] ph_thresh_q;

  // bin accumulators
  logic [MicIdxW-1:0]         cnt_q;
  logic [MagSumW-1:0]         mag_sum_q;
  logic [PhSumW-1:0]          pds_q;
  logic [AngleWidth-1:0]      ap_q [MaxMics];
  logic signed [SampleWidth-1:0] ref_re_q, ref_im_q;
  logic                       ref_pass_q;

  // current beat
  logic signed [SampleWidth-1:0] re_q, im_q;
  logic [AngleWidth-1:0]      steer_q;
  logic                       dc_q;

  // shared multiplier
  logic [SampleWidth-1:0] mul_a, mul_b;
  logic [ProdW-1:0]       mul_p, prod_q, sq_q;

  // root and CORDIC
  logic [ProdW-1:0]   v_q, r_q, bit_q;
  logic signed [CordicW-1:0] x_q, y_q;
  logic [31:0]        a_q;
  logic               zero_q;
  logic [4:0]         it_q;
  logic [AngleWidth-1:0] ph_q;
  logic [MicIdxW-1:0] pi_q;

  // divider
  logic [ProdW-1:0]       num_q, quo_q;
  logic [SampleWidth-1:0] den_q, rem_q;
  logic [5:0]             dcnt_q;
  logic [SampleWidth:0]   rem_sh;
  logic                   rem_ge;

  // bin result
  logic [CountW-1:0]      k_q;
  logic [SampleWidth-1:0] mean_q, m_q, m0_q;
  logic                   coh_q, comp_q;
  logic signed [SampleWidth-1:0] enh_re_q, enh_im_q, itf_re_q, itf_im_q;
  logic                   out_valid_q;

  // helpers
  logic [CountW-1:0]  n_clamp, k_now;
  logic               bin_done;
  logic [AngleWidth-1:0] d_raw, d_fold;
  logic [31:0]        a_rnd;
  logic [5:0]         pairs;
  logic [PhSumW-1:0]  ph_limit;
  logic               coh_now;
  logic [39:0]        att_sum;
  logic signed [SampleWidth-1:0] sel_re, sel_im, comp_val;
  logic signed [SampleWidth:0]   sel_re_x;
  logic [SampleWidth-1:0] scl_res;
  logic               out_free;

  function automatic logic [SampleWidth-1:0] mag_abs(input logic signed [SampleWidth-1:0] v);
    return v[SampleWidth-1] ? (~v + 1'b1) : v;
  endfunction

  // ---------------- combinational helpers
  always_comb begin
    if (mic_count_q < 4'd2) begin
      n_clamp = 4'd2;
    end else if (mic_count_q > CountW'(MaxMics)) begin
      n_clamp = CountW'(MaxMics);
    end else begin
      n_clamp = mic_count_q;
    end
  end

  assign k_now    = {1'b0, cnt_q} + 4'd1;
  assign bin_done = (k_now >= n_clamp);

  assign d_raw  = ap_q[pi_q] - ph_q;
  assign d_fold = (d_raw > Half) ? (~d_raw + 1'b1) : d_raw;
  assign a_rnd  = a_q + 32'h0000_8000;

  assign pairs    = ({2'b00, k_q} * ({2'b00, k_q} - 6'd1)) >> 1;
  assign ph_limit = PhSumW'(ph_thresh_q) * PhSumW'(pairs);
  assign coh_now  = ((mean_q >> window_log2_q) > {1'b0, mag_thresh_q}) && (pds_q < ph_limit);
  assign att_sum  = prod_q[39:0] + 40'h8000;

  assign sel_re   = ref_pass_q ? ref_re_q : re_q;
  assign sel_im   = ref_pass_q ? ref_im_q : im_q;
  assign sel_re_x = sel_re[SampleWidth-1] ? -{sel_re[SampleWidth-1], sel_re}
                                          : {sel_re[SampleWidth-1], sel_re};
  assign comp_val = comp_q ? ref_im_q : ref_re_q;

  assign rem_sh = {rem_q, num_q[ProdW-1]};
  assign rem_ge = (rem_sh >= {1'b0, den_q});

  always_comb begin
    if (comp_val[SampleWidth-1]) begin
      scl_res = (quo_q >= ProdW'(SatLo)) ? SatLo : (~quo_q[SampleWidth-1:0] + 1'b1);
    end else begin
      scl_res = (quo_q >= ProdW'(SatHi)) ? SatHi : quo_q[SampleWidth-1:0];
    end
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign mul_p    = ProdW'(mul_a) * ProdW'(mul_b);

  // ---------------- sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:     if (in_valid_i) state_d = ST_SQ_RE;
      ST_SQ_RE:    state_d = ST_SQ_IM;
      ST_SQ_IM:    state_d = ST_ROOT_LD;
      ST_ROOT_LD:  state_d = ST_ROOT_VEC;
      ST_ROOT_VEC: if (it_q == 5'd31) state_d = ST_FIX;
      ST_FIX: begin
        if (!ref_pass_q) begin
          state_d = ST_PAIR;
        end else if (r_q == '0) begin
          state_d = ST_OUT;
        end else begin
          state_d = ST_SCL_MUL;
        end
      end
      ST_PAIR: begin
        if (pi_q >= cnt_q) begin
          state_d = bin_done ? ST_MEAN_DIV : ST_IDLE;
        end
      end
      ST_MEAN_DIV: if (dcnt_q == 6'd47) state_d = ST_DECIDE;
      ST_DECIDE:   state_d = dc_q ? ST_OUT : ST_GAIN;
      ST_GAIN:     state_d = ST_SELECT;
      ST_SELECT:   state_d = ST_SQ_RE;
      ST_SCL_MUL:  state_d = ST_SCL_DIV;
      ST_SCL_DIV:  if (dcnt_q == 6'd47) state_d = ST_SCL_FIX;
      ST_SCL_FIX:  state_d = comp_q ? ST_OUT : ST_SCL_MUL;
      ST_OUT:      if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------- sequencer: outputs and multiplier operands
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_SQ_RE: begin
        mul_a = mag_abs(sel_re);
        mul_b = mag_abs(sel_re);
      end
      ST_SQ_IM: begin
        mul_a = mag_abs(sel_im);
        mul_b = mag_abs(sel_im);
      end
      ST_GAIN: begin
        mul_a = mean_q;
        mul_b = {8'd0, atten_gain_q};
      end
      ST_SCL_MUL: begin
        mul_a = m_q;
        mul_b = mag_abs(comp_val);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // ---------------- control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      mic_count_q   <= 4'd4;
      window_log2_q <= 4'd9;
      mag_thresh_q  <= 23'd1;
      atten_gain_q  <= 16'd6554;
      ph_thresh_q   <= 15'd1820;
      cnt_q         <= '0;
      mag_sum_q     <= '0;
      pds_q         <= '0;
      ref_re_q      <= '0;
      ref_im_q      <= '0;
      ref_pass_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_MIC_COUNT:   mic_count_q   <= cfg_wdata_i[3:0];
          REG_WINDOW_LOG2: window_log2_q <= cfg_wdata_i[3:0];
          REG_MAG_THRESH:  mag_thresh_q  <= cfg_wdata_i;
          REG_ATTEN_GAIN:  atten_gain_q  <= cfg_wdata_i[15:0];
          REG_PH_THRESH:   ph_thresh_q   <= cfg_wdata_i[14:0];
          default: ;
        endcase
      end
      if (state_q == ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i && cnt_q == '0) begin
            ref_re_q  <= bin_re_i;
            ref_im_q  <= bin_im_i;
            mag_sum_q <= '0;
            pds_q     <= '0;
          end
        end
        ST_FIX: begin
          if (!ref_pass_q) mag_sum_q <= mag_sum_q + MagSumW'(r_q[SampleWidth-1:0]);
        end
        ST_PAIR: begin
          if (pi_q < cnt_q) begin
            pds_q <= pds_q + PhSumW'(d_fold);
          end else begin
            cnt_q <= bin_done ? '0 : k_now[MicIdxW-1:0];
          end
        end
        ST_SELECT: ref_pass_q <= 1'b1;
        ST_OUT: begin
          if (out_free) ref_pass_q <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------- datapath
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          re_q    <= bin_re_i;
          im_q    <= bin_im_i;
          steer_q <= steer_phase_i;
          dc_q    <= dc_bin_i;
        end
      end
      ST_SQ_IM: sq_q <= prod_q;
      ST_ROOT_LD: begin
        v_q    <= sq_q + prod_q;
        r_q    <= '0;
        bit_q  <= ProdW'(1) << 46;
        it_q   <= '0;
        zero_q <= (sel_re == '0) && (sel_im == '0);
        x_q    <= CordicW'(sel_re_x) <<< 16;
        y_q    <= sel_re[SampleWidth-1] ? -(CordicW'(sel_im) <<< 16) : (CordicW'(sel_im) <<< 16);
        a_q    <= sel_re[SampleWidth-1] ? 32'h8000_0000 : 32'h0;
      end
      ST_ROOT_VEC: begin
        it_q <= it_q + 5'd1;
        if (bit_q != '0) begin
          if (v_q >= r_q + bit_q) begin
            v_q <= v_q - (r_q + bit_q);
            r_q <= (r_q >> 1) + bit_q;
          end else begin
            r_q <= r_q >> 1;
          end
          bit_q <= bit_q >> 2;
        end
        if (!y_q[CordicW-1]) begin
          x_q <= x_q + (y_q >>> it_q);
          y_q <= y_q - (x_q >>> it_q);
          a_q <= a_q + atan_turn(it_q);
        end else begin
          x_q <= x_q - (y_q >>> it_q);
          y_q <= y_q + (x_q >>> it_q);
          a_q <= a_q - atan_turn(it_q);
        end
      end
      ST_FIX: begin
        if (!ref_pass_q) begin
          ph_q <= (zero_q ? '0 : a_rnd[31:16]) - steer_q;
          pi_q <= '0;
        end else begin
          m0_q <= r_q[SampleWidth-1:0];
          comp_q <= 1'b0;
          if (r_q == '0) begin
            enh_re_q <= (m_q > SatHi) ? SatHi : m_q;
            enh_im_q <= '0;
          end
        end
      end
      ST_PAIR: begin
        if (pi_q < cnt_q) begin
          pi_q <= pi_q + 1'b1;
        end else begin
          ap_q[cnt_q] <= ph_q;
          k_q    <= k_now;
          num_q  <= ProdW'(mag_sum_q);
          den_q  <= SampleWidth'(k_now);
          rem_q  <= '0;
          quo_q  <= '0;
          dcnt_q <= '0;
        end
      end
      ST_MEAN_DIV, ST_SCL_DIV: begin
        rem_q  <= rem_ge ? SampleWidth'(rem_sh - {1'b0, den_q}) : rem_sh[SampleWidth-1:0];
        quo_q  <= {quo_q[ProdW-2:0], rem_ge};
        num_q  <= num_q << 1;
        dcnt_q <= dcnt_q + 6'd1;
      end
      ST_DECIDE: begin
        mean_q <= quo_q[SampleWidth-1:0];
        if (dc_q) begin
          enh_re_q <= ref_re_q;
          enh_im_q <= ref_im_q;
          itf_re_q <= ref_re_q;
          itf_im_q <= ref_im_q;
        end
      end
      ST_GAIN: coh_q <= coh_now;
      ST_SELECT: begin
        m_q      <= coh_q ? mean_q : att_sum[39:16];
        itf_re_q <= coh_q ? '0 : ref_re_q;
        itf_im_q <= coh_q ? '0 : ref_im_q;
      end
      ST_SCL_MUL: begin
        num_q  <= mul_p + ProdW'(m0_q >> 1);
        den_q  <= m0_q;
        rem_q  <= '0;
        quo_q  <= '0;
        dcnt_q <= '0;
      end
      ST_SCL_FIX: begin
        if (comp_q) begin
          enh_im_q <= scl_res;
        end else begin
          enh_re_q <= scl_res;
        end
        comp_q <= 1'b1;
      end
      ST_OUT: begin
        if (out_free) begin
          enhanced_re_o     <= enh_re_q;
          enhanced_im_o     <= enh_im_q;
          interference_re_o <= itf_re_q;
          interference_im_o <= itf_im_q;
        end
      end
      default: ;
    endcase
  end

  `include "assert_macros.svh"

  `ASSERT_CLK(a_root_before_angle, ((state_q == ST_ROOT_VEC) && (it_q == 5'd31)) |-> (bit_q == '0), "root not finished when CORDIC ends")
  `ASSERT_CLK(a_div_rem_bound, ((state_q == ST_MEAN_DIV) || (state_q == ST_SCL_DIV)) |-> (rem_q < den_q), "divider remainder not below divisor")
  `ASSERT_NEVER(a_phase_sum_bound, pds_q > PhSumMax, "phase difference sum beyond pair count")

endmodule

`default_nettype wire
